// ===== src/tcw_pkg.sv =====
// Shared types, constants and helpers for the texture coordinate tile/wrap block.
package tcw_pkg;

  // Largest image dimension the block supports.
  localparam int MAX_DIM = 16384;

  localparam int OFF_W  = 32;                        // offset register width
  localparam int DEV_W  = 16;                        // device coordinate width
  localparam int IMG_W  = 15;                        // image size register width
  localparam int MODE_W = 2;
  localparam int OUT_W  = 14;                        // source index width
  localparam int IDX_W  = 8;                         // config register index width
  localparam int DATA_W = 32;                        // config write data width

  localparam int N_W    = $clog2(MAX_DIM + 1);       // effective size width
  localparam int M_W    = N_W + 1;                   // width of twice the size
  localparam int SUM_W  = OFF_W + 1;                 // offset + device coordinate
  localparam int DIG    = 4;                         // dividend bits per stage
  localparam int DIV_ST = (SUM_W + DIG - 1) / DIG;   // remainder stages
  localparam int DVD_W  = DIV_ST * DIG;
  localparam int NSTAGE = DIV_ST + 4;                // sum, abs, remainder, fix, select

  // Tile mode codes; the unused code behaves as clamp.
  localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_OFFSET_X     = 8'd0;
  localparam logic [IDX_W-1:0] CFG_OFFSET_Y     = 8'd1;
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd2;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd3;
  localparam logic [IDX_W-1:0] CFG_TILE_MODE    = 8'd4;

  typedef struct packed {
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [N_W-1:0]          size_x;
    logic [N_W-1:0]          size_y;
    logic [MODE_W-1:0]       mode;
  } cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

  // Zero size acts as one, oversized acts as the maximum.
  function automatic logic [N_W-1:0] eff_size(input logic [IMG_W-1:0] raw);
    logic [N_W-1:0] r;
    if (raw == '0) begin
      r = N_W'(1);
    end else if (32'(raw) > MAX_DIM) begin
      r = N_W'(MAX_DIM);
    end else begin
      r = N_W'(raw);
    end
    return r;
  endfunction

endpackage

// ===== src/tcw_in_if.sv =====
// Input channel: device coordinates and span-end mark.
interface tcw_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [16-1:0]    dev_x;
  logic signed [16-1:0]    dev_y;
  logic                    span_last;

  modport source (output valid, output dev_x, output dev_y, output span_last, input ready);
  modport sink   (input valid, input dev_x, input dev_y, input span_last, output ready);
endinterface

// ===== src/tcw_out_if.sv =====
// Result channel: tiled source column and row with span-end mark.
interface tcw_out_if;
  logic          valid;
  logic          ready;
  logic [14-1:0] src_x;
  logic [14-1:0] src_y;
  logic          last_out;

  modport source (output valid, output src_x, output src_y, output last_out, input ready);
  modport sink   (input valid, input src_x, input src_y, input last_out, output ready);
endinterface

// ===== src/tcw_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface tcw_cfg_if;
  logic          valid;
  logic          ready;
  logic [8-1:0]  index;
  logic [32-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/texture_coord_tile_wrap_top.sv =====
// Top level of the texture coordinate tile/wrap block.
// Maps each device pixel (dev_x, dev_y) to a source column and row: adds the
// configured signed offsets, then clamps, repeats or mirrors each sum into the
// image size (the same tile mode on both axes). Throughput is one pixel per
// clock while the output is ready or a stage is empty. The registered path
// runs through the 33-bit floor-remainder pipeline, which retires 4 dividend
// bits per stage (9 stages) between the add/abs front and the fold/select back
// end. Stages hold under back-pressure and empty stages fill in, so input
// keeps flowing while a result waits. There is no clearing pass after reset.
// Write configuration only while the pipeline is empty.
module texture_coord_tile_wrap_top import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_if,
  tcw_out_if.source out_if,
  tcw_cfg_if.sink   cfg_if
);

  cfg_t      cfg;
  pipe_ctl_t ctl;

  tcw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .wr_ready (cfg_if.ready),
    .cfg      (cfg)
  );

  tcw_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.span_last),
    .out_ready (out_if.ready),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_last  (out_if.last_out),
    .ctl       (ctl)
  );

  tcw_axis_pipe u_axis_x (
    .clk    (clk),
    .ctl    (ctl),
    .offset (cfg.off_x),
    .dev    (in_if.dev_x),
    .size   (cfg.size_x),
    .mode   (cfg.mode),
    .src    (out_if.src_x)
  );

  tcw_axis_pipe u_axis_y (
    .clk    (clk),
    .ctl    (ctl),
    .offset (cfg.off_y),
    .dev    (in_if.dev_y),
    .size   (cfg.size_y),
    .mode   (cfg.mode),
    .src    (out_if.src_y)
  );

endmodule

// ===== src/tcw_cfg_regs.sv =====
// Configuration registers and effective image sizes.
module tcw_cfg_regs import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output logic              wr_ready,
  output cfg_t              cfg
);

  logic signed [OFF_W-1:0] off_x_r;
  logic signed [OFF_W-1:0] off_y_r;
  logic [IMG_W-1:0]        width_r;
  logic [IMG_W-1:0]        height_r;
  logic [MODE_W-1:0]       mode_r;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      width_r  <= IMG_W'(1);
      height_r <= IMG_W'(1);
      mode_r   <= MODE_CLAMP;
    end else if (wr_valid) begin
      // indexes past the register list are dropped
      unique case (wr_index)
        CFG_OFFSET_X:     off_x_r  <= wr_data[OFF_W-1:0];
        CFG_OFFSET_Y:     off_y_r  <= wr_data[OFF_W-1:0];
        CFG_IMAGE_WIDTH:  width_r  <= wr_data[IMG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= wr_data[IMG_W-1:0];
        CFG_TILE_MODE:    mode_r   <= wr_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.off_x  = off_x_r;
    cfg.off_y  = off_y_r;
    cfg.size_x = eff_size(width_r);
    cfg.size_y = eff_size(height_r);
    cfg.mode   = mode_r;
  end

endmodule

// ===== src/tcw_pipe_ctrl.sv =====
// Valid bits, span-end marks and per-stage load enables of the pipeline.
module tcw_pipe_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output logic      out_last,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] last_r;
  logic [NSTAGE-1:0] low_mask [NSTAGE];

  // A stage loads when it or any stage after it is empty, or the output drains.
  always_comb begin
    for (int i = 0; i < NSTAGE; i++) begin
      low_mask[i] = (NSTAGE'(1) << i) - NSTAGE'(1);
      ctl.en[i]   = out_ready || ((valid_r | low_mask[i]) != '1);
    end
  end

  assign in_ready  = ctl.en[0];
  assign out_valid = valid_r[NSTAGE-1];
  assign out_last  = last_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (ctl.en[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      last_r[0] <= in_last;
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (ctl.en[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  // A later stage never loads while an earlier one is held.
  a_en_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.en[NSTAGE-1] |-> ctl.en[0])
    else $error("stage enables out of order");

  // Input is refused only with every stage full, and then nothing moves.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.en[0] |-> (&valid_r) ##1 (valid_r == $past(valid_r)))
    else $error("pipeline moved while input was refused");

  // Occupancy follows accepted and delivered transactions exactly.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones(valid_r) == $past($countones(valid_r))
        + ($past(in_valid && in_ready) ? 1 : 0)
        - ($past(out_valid && out_ready) ? 1 : 0))
    else $error("pipeline occupancy lost or gained a transaction");

endmodule

// ===== src/tcw_axis_pipe.sv =====
// One axis datapath: translate, clamp, remainder by twice the size, fold.
module tcw_axis_pipe import tcw_pkg::*; (
  input  logic                    clk,
  input  pipe_ctl_t               ctl,
  input  logic signed [OFF_W-1:0] offset,
  input  logic signed [DEV_W-1:0] dev,
  input  logic [N_W-1:0]          size,
  input  logic [MODE_W-1:0]       mode,
  output logic [OUT_W-1:0]        src
);

  localparam int S_ABS  = 1;
  localparam int S_DIV0 = 2;
  localparam int S_FIX  = S_DIV0 + DIV_ST;
  localparam int S_SEL  = S_FIX + 1;

  logic [M_W-1:0] m;
  assign m = {size, 1'b0};

  // stage 0: sum
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  // stage 1: sign, magnitude, clamp result
  logic                    neg_r, neg_nxt;
  logic [DVD_W-1:0]        mag_r, mag_nxt;
  logic [N_W-1:0]          clamp_r, clamp_nxt;
  logic [SUM_W-1:0]        abs_v;
  // remainder stages
  logic [M_W-1:0]          rem_r    [DIV_ST];
  logic [M_W-1:0]          rem_nxt  [DIV_ST];
  logic [DVD_W-1:0]        dvd_r    [DIV_ST];
  logic [DVD_W-1:0]        dvd_nxt  [DIV_ST];
  logic                    dneg_r   [DIV_ST];
  logic                    dneg_nxt [DIV_ST];
  logic [N_W-1:0]          dcl_r    [DIV_ST];
  logic [N_W-1:0]          dcl_nxt  [DIV_ST];
  logic [M_W-1:0]          cr;
  logic [DVD_W-1:0]        cd;
  logic [M_W:0]            t;
  // fix stage: floor remainder
  logic [M_W-1:0]          fix_r, fix_nxt;
  logic [N_W-1:0]          fcl_r;
  // select stage
  logic [M_W-1:0]          n_m;
  logic [M_W-1:0]          fold;
  logic [OUT_W-1:0]        res_r, res_nxt;

  always_comb begin
    sum_nxt = SUM_W'(offset) + SUM_W'(dev);
  end

  always_comb begin
    neg_nxt = sum_r[SUM_W-1];
    abs_v   = neg_nxt ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    mag_nxt = DVD_W'(abs_v);
    if (neg_nxt) begin
      clamp_nxt = '0;
    end else if (sum_r >= $signed(SUM_W'(size))) begin
      clamp_nxt = size - N_W'(1);
    end else begin
      clamp_nxt = sum_r[N_W-1:0];
    end
  end

  // Restoring remainder, DIG dividend bits per stage, MSB first.
  always_comb begin
    cr = '0;
    cd = '0;
    t  = '0;
    for (int k = 0; k < DIV_ST; k++) begin
      if (k == 0) begin
        cr          = '0;
        cd          = mag_r;
        dneg_nxt[k] = neg_r;
        dcl_nxt[k]  = clamp_r;
      end else begin
        cr          = rem_r[k-1];
        cd          = dvd_r[k-1];
        dneg_nxt[k] = dneg_r[k-1];
        dcl_nxt[k]  = dcl_r[k-1];
      end
      for (int d = 0; d < DIG; d++) begin
        t  = {cr, cd[DVD_W-1]};
        cd = cd << 1;
        if (t >= {1'b0, m}) begin
          t = t - {1'b0, m};
        end
        cr = t[M_W-1:0];
      end
      rem_nxt[k] = cr;
      dvd_nxt[k] = cd;
    end
  end

  // Negative input with nonzero remainder wraps up from the divisor.
  always_comb begin
    if (dneg_r[DIV_ST-1] && (rem_r[DIV_ST-1] != '0)) begin
      fix_nxt = m - rem_r[DIV_ST-1];
    end else begin
      fix_nxt = rem_r[DIV_ST-1];
    end
  end

  always_comb begin
    n_m  = M_W'(size);
    fold = fix_r;
    unique case (mode)
      MODE_REPEAT: begin
        if (fix_r >= n_m) fold = fix_r - n_m;
        res_nxt = OUT_W'(fold[N_W-1:0]);
      end
      MODE_MIRROR: begin
        // reflect the upper half back down
        if (fix_r >= n_m) fold = m - M_W'(1) - fix_r;
        res_nxt = OUT_W'(fold[N_W-1:0]);
      end
      default: begin
        res_nxt = OUT_W'(fcl_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      sum_r <= sum_nxt;
    end
    if (ctl.en[S_ABS]) begin
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      clamp_r <= clamp_nxt;
    end
    for (int k = 0; k < DIV_ST; k++) begin
      if (ctl.en[S_DIV0+k]) begin
        rem_r[k]  <= rem_nxt[k];
        dvd_r[k]  <= dvd_nxt[k];
        dneg_r[k] <= dneg_nxt[k];
        dcl_r[k]  <= dcl_nxt[k];
      end
    end
    if (ctl.en[S_FIX]) begin
      fix_r <= fix_nxt;
      fcl_r <= dcl_r[DIV_ST-1];
    end
    if (ctl.en[S_SEL]) begin
      res_r <= res_nxt;
    end
  end

  assign src = res_r;

endmodule
